// File: rtl/vlcp_pkg.sv
// Shared types and constants for the variable-length code packer.
package vlcp_pkg;

  // Fixed field widths.
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int SYM_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int BUF_W   = CODE_W + BYTE_W;

  // Table size and the longest code that a load may store.
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int TABLE_DEPTH  = 256;
  localparam int TIDX_W       = $clog2(TABLE_DEPTH);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input opcodes.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  // Kind of work handed to the back.
  typedef enum logic {
    ENT_ENCODE = 1'b0,
    ENT_FLUSH  = 1'b1
  } ent_kind_t;

  // One code table entry; the code is stored left-aligned.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } table_ent_t;

  // One queued command.
  typedef struct packed {
    ent_kind_t         kind;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } q_entry_t;

endpackage

// File: rtl/variable_length_code_packer_top.sv
// Top level of the variable-length code packer.
//
//   channel  | handshake        | beat fields
//   ---------+------------------+-----------------------------------------------
//   input    | in_push/in_full  | in_opcode, in_symbol, in_code_value, in_code_length
//   result   | out_empty/out_pop| out_data_byte, out_last_byte
//
// A load or opcode 3 beat is done in the cycle it is accepted; an encode or flush
// reaches the packer through a registered table read and a four-entry command
// queue. The packer takes one command per cycle while under a byte is pending
// and drains each completed byte before the next, holding while the output
// register is full; the single output byte port sets the sustained rate.
// Reset (rst_n low, synchronous) clears the bit buffer, queue and output; the
// code table is not cleared. in_full rises only when the queue may fill up.
module variable_length_code_packer_top
  import vlcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_opcode,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_value,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic              out_last_byte
);

  logic              q_push;
  q_entry_t          q_in;
  logic              q_pop;
  q_entry_t          q_head;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  vlcp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_entry        (q_in)
  );

  vlcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .count      (q_count)
  );

  vlcp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data_byte (out_data_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

// File: rtl/vlcp_front.sv
// Front end: accepts beats, keeps the code table and queues encode and flush work.
module vlcp_front
  import vlcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_opcode,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_value,
  input  logic [LEN_W-1:0]  in_code_length,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output q_entry_t          q_entry
);

  table_ent_t code_table [TABLE_DEPTH];
  table_ent_t rd_ent_r;
  logic       p1_valid_r, p1_valid_nxt;
  ent_kind_t  p1_kind_r, p1_kind_nxt;

  logic              accept;
  logic              sym_ok;
  logic              len_ok;
  logic [LEN_W-1:0]  align_shift;
  logic [CODE_W-1:0] code_left;
  logic              do_load;

  // Hold off new beats while the queue might not take what is in flight.
  assign in_full = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(p1_valid_r))
                   >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept  = in_push && !in_full;

  // Range checks on the loaded entry and the symbol.
  assign sym_ok = ({1'b0, in_symbol} < (SYM_W+1)'(SYMBOL_COUNT));
  assign len_ok = ({1'b0, in_code_length} <= (LEN_W+1)'(MAX_CODE_LEN)) &&
                  ({1'b0, in_code_length} <= (LEN_W+1)'(CODE_W));

  // Left-align the code; the shift also drops bits above the length.
  assign align_shift = LEN_W'(CODE_W) - in_code_length;
  assign code_left   = in_code_value << align_shift;
  assign do_load     = accept && (in_opcode == OP_LOAD) && sym_ok && len_ok;

  // Code table: one write port for loads, one registered read for encodes.
  always_ff @(posedge clk) begin
    if (do_load) begin
      code_table[TIDX_W'(in_symbol)] <= '{code: code_left, len: in_code_length};
    end
    rd_ent_r <= code_table[TIDX_W'(in_symbol)];
  end

  // Classify the accepted beat.
  always_comb begin
    p1_valid_nxt = 1'b0;
    p1_kind_nxt  = ENT_ENCODE;
    if (accept) begin
      case (in_opcode)
        OP_ENCODE: begin
          p1_valid_nxt = sym_ok;
          p1_kind_nxt  = ENT_ENCODE;
        end
        OP_FLUSH: begin
          p1_valid_nxt = 1'b1;
          p1_kind_nxt  = ENT_FLUSH;
        end
        default: begin
          p1_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
    end
    p1_kind_r <= p1_kind_nxt;
  end

  // Queue the command together with the table read.
  assign q_push        = p1_valid_r;
  assign q_entry.kind  = p1_kind_r;
  assign q_entry.code  = rd_ent_r.code;
  assign q_entry.len   = rd_ent_r.len;

endmodule

// File: rtl/vlcp_queue.sv
// Small command queue between the front end and the bit packer.
module vlcp_queue
  import vlcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  q_entry_t          push_entry,
  input  logic              pop,
  output q_entry_t          head,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign head   = slots[rd_ptr_r];
  assign do_pop = pop && !empty;

  // Pointer and count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/vlcp_back.sv
// Back end: merges codes into the bit buffer, one byte per cycle when popped.
module vlcp_back
  import vlcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_entry_t          q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic              out_last_byte
);

  // Pending bits, left-aligned, and how many of them are valid.
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [LEN_W-1:0]  tot_r, tot_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              emit;
  logic [BUF_W-1:0]  merged;

  assign slot_free = !out_valid_r || out_pop;

  // Append the new code right after the pending bits.
  assign merged = buf_r | ({q_head.code, BYTE_W'(0)} >> tot_r[2:0]);

  // Either drain one full byte or take the next command.
  always_comb begin
    buf_nxt      = buf_r;
    tot_nxt      = tot_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    if (tot_r >= LEN_W'(BYTE_W)) begin
      if (slot_free) begin
        emit         = 1'b1;
        out_byte_nxt = buf_r[BUF_W-1 -: BYTE_W];
        out_last_nxt = 1'b0;
        buf_nxt      = buf_r << BYTE_W;
        tot_nxt      = tot_r - LEN_W'(BYTE_W);
      end
    end else if (!q_empty) begin
      case (q_head.kind)
        ENT_ENCODE: begin
          q_pop   = 1'b1;
          buf_nxt = merged;
          tot_nxt = tot_r + q_head.len;
        end
        ENT_FLUSH: begin
          if (tot_r == '0) begin
            q_pop = 1'b1;
          end else if (slot_free) begin
            q_pop        = 1'b1;
            emit         = 1'b1;
            out_byte_nxt = buf_r[BUF_W-1 -: BYTE_W];
            out_last_nxt = 1'b1;
            buf_nxt      = '0;
            tot_nxt      = '0;
          end
        end
        default: begin
          q_pop = 1'b0;
        end
      endcase
    end
  end

  // Output register.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      buf_r       <= buf_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_empty     = !out_valid_r;
  assign out_data_byte = out_byte_r;
  assign out_last_byte = out_last_r;

  // The buffer never holds more than seven pending bits plus one code.
  a_tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= LEN_W'(BUF_W - 1))
    else $error("bit buffer count out of range");

  // With less than a byte pending, nothing stands below the top byte.
  a_buf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (tot_r < LEN_W'(BYTE_W)) |-> (buf_r[CODE_W-1:0] == '0))
    else $error("stray bits below the pending byte");

  // A flush with pending bits leaves a last byte and an empty buffer.
  a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.kind == ENT_FLUSH && tot_r != '0) |=>
      (!out_empty && out_last_byte && tot_r == '0))
    else $error("flush did not produce a last byte");

endmodule

// File: test/variable_length_code_packer_top_tb.sv
// Self-checking testbench for the variable-length code packer top level.
module variable_length_code_packer_top_tb;
  import vlcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode that the block must ignore.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int RANDOM_ITEMS   = 215;
  localparam int CALM_ITEMS     = 60;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [1:0]        in_opcode;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code_value;
  logic [LEN_W-1:0]  in_code_length;
  logic              out_empty;
  logic              out_pop;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_last_byte;

  // Predicted code table and bit packer state.
  logic [CODE_W-1:0] code_bits [TABLE_DEPTH];
  logic [LEN_W-1:0]  code_len  [TABLE_DEPTH];
  bit                loaded    [TABLE_DEPTH];
  logic [BYTE_W-1:0] pack_acc;
  int                pack_cnt;
  packed_byte_t      expected_bytes[$];

  int error_count = 0;
  int stuck_cycles = 0;
  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold_req;

  variable_length_code_packer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_data_byte  (out_data_byte),
    .out_last_byte  (out_last_byte)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Updates the predicted state for one accepted beat and queues its bytes.
  function automatic void predict_beat(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                                       input logic [CODE_W-1:0] val,
                                       input logic [LEN_W-1:0] len);
    logic [63:0]  mask;
    packed_byte_t item;
    int           i;
    case (op)
      OP_LOAD: begin
        // Overlong codes leave the entry alone; stray high bits are dropped.
        if (len <= MAX_CODE_LEN && int'(sym) < SYMBOL_COUNT) begin
          mask = (64'd1 << len) - 64'd1;
          code_bits[sym] = val & mask[CODE_W-1:0];
          code_len[sym]  = len;
          loaded[sym]    = 1'b1;
        end
      end
      OP_ENCODE: begin
        // Shift the code in first bit first and emit each full byte.
        if (int'(sym) < SYMBOL_COUNT) begin
          for (i = int'(code_len[sym]); i > 0; i--) begin
            pack_acc = {pack_acc[BYTE_W-2:0], code_bits[sym][i-1]};
            pack_cnt++;
            if (pack_cnt == BYTE_W) begin
              item.data = pack_acc;
              item.last = 1'b0;
              expected_bytes = {expected_bytes, item};
              pack_acc = '0;
              pack_cnt = 0;
            end
          end
        end
      end
      OP_FLUSH: begin
        // Only a partial byte is padded and given out.
        if (pack_cnt != 0) begin
          item.data = pack_acc << (BYTE_W - pack_cnt);
          item.last = 1'b1;
          expected_bytes = {expected_bytes, item};
          pack_acc = '0;
          pack_cnt = 0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one beat, possibly after a short gap, and waits until it is taken.
  task automatic send_beat(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] val, input logic [LEN_W-1:0] len);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        in_push <= 1'b0;
      end
    end
    @(negedge clk);
    in_push        <= 1'b1;
    in_opcode      <= op;
    in_symbol      <= sym;
    in_code_value  <= val;
    in_code_length <= len;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_beat(op, sym, val, len);
  endtask

  task automatic send_encode(input logic [SYM_W-1:0] sym);
    send_beat(OP_ENCODE, sym, $urandom, LEN_W'($urandom));
  endtask

  task automatic send_flush();
    send_beat(OP_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
  endtask

  // Stops offering beats and waits until every predicted byte has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Random symbol among the loaded entries.
  function automatic logic [SYM_W-1:0] pick_loaded_symbol();
    logic [SYM_W-1:0] s;
    s = SYM_W'($urandom_range(0, TABLE_DEPTH - 1));
    while (!loaded[s]) s = s + 1'b1;
    return s;
  endfunction

  // Table writes at the field extremes, plus beats the block must ignore.
  task automatic test_table_loads();
    send_beat(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
    send_beat(OP_LOAD, 8'd255, 32'hFFFF_FFFE, 6'd1);
    send_beat(OP_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd0);
    send_beat(OP_LOAD, 8'd2, 32'h0000_00A5, 6'd8);
    send_beat(OP_LOAD, 8'd3, 32'hDEAD_BEE5, 6'd3);
    send_beat(OP_LOAD, 8'd3, 32'h0000_0000, 6'd63);
    send_beat(OP_LOAD, 8'd3, 32'h5555_5555, 6'd33);
    send_beat(OP_LOAD, 8'd4, 32'h8000_0001, 6'd32);
    send_beat(OP_RESERVED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
  endtask

  // Short encode and flush sequences covering the corner cases.
  task automatic test_directed_stream();
    send_flush();       // nothing pending
    send_encode(8'd2);  // exactly one byte
    send_encode(8'd1);  // zero-length code
    send_flush();       // still nothing pending
    send_encode(8'd3);
    send_encode(8'd0);  // four bytes with three bits left over
    send_beat(OP_RESERVED, 8'h00, 32'h0, 6'd0);
    send_encode(8'd255);
    send_flush();
    send_encode(8'd4);
    send_encode(8'd3);
    send_encode(8'd3);
    send_encode(8'd255);
    send_encode(8'd4);  // seven bits pending plus a full-width code
    send_flush();
  endtask

  // The result side holds off long enough for the block to fill and stall.
  task automatic test_output_stall();
    rx_hold_req = 1'b1;
    repeat (24) send_encode(8'd0);
    drain_results();
  endtask

  // A burst, then a pause until every byte is out, then another burst.
  task automatic test_sender_pause();
    repeat (6) send_encode(pick_loaded_symbol());
    send_flush();
    drain_results();
    repeat (6) send_encode(pick_loaded_symbol());
    send_flush();
  endtask

  // Runs of encodes, often closed by flushes, with table updates and some noise mixed in.
  task automatic test_random_stream();
    int counted;
    int run;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= RANDOM_ITEMS - CALM_ITEMS) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      run = $urandom_range(1, 10);
      repeat (run) send_encode(pick_loaded_symbol());
      counted += run;
      if ($urandom_range(0, 9) < 6) begin
        send_flush();
        counted++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_beat(OP_LOAD, SYM_W'($urandom), $urandom, LEN_W'($urandom_range(0, MAX_CODE_LEN)));
        counted++;
      end
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send_beat(OP_LOAD, SYM_W'($urandom), $urandom,
                    LEN_W'($urandom_range(MAX_CODE_LEN + 1, 63)));
        end else begin
          send_beat(OP_RESERVED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        end
      end
    end
  endtask

  // Result side: pop with random stalls, or a long counted hold on request.
  initial begin : result_pop_drive
    int gap;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_pop <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4);
        out_pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Compare each popped beat with the oldest predicted byte.
  always @(posedge clk) begin : result_check
    packed_byte_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  out_data_byte, out_last_byte));
      end else begin
        want = expected_bytes[0];
        expected_bytes.delete(0);
        if (out_data_byte !== want.data)
          report_mismatch($sformatf("data_byte %02h, predicted %02h", out_data_byte, want.data));
        if (out_last_byte !== want.last)
          report_mismatch($sformatf("last_byte %0b, predicted %0b", out_last_byte, want.last));
      end
    end
  end

  // End the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("variable_length_code_packer_top test failed");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_opcode      = '0;
    in_symbol      = '0;
    in_code_value  = '0;
    in_code_length = '0;
    pack_acc       = '0;
    pack_cnt       = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rx_hold_req    = 1'b0;
    foreach (loaded[i]) begin
      loaded[i]    = 1'b0;
      code_bits[i] = '0;
      code_len[i]  = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_table_loads();
    test_directed_stream();
    test_output_stall();
    test_sender_pause();
    test_random_stream();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("variable_length_code_packer_top test passed");
    end else begin
      $display("variable_length_code_packer_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/vlcp_pkg.sv
rtl/vlcp_front.sv
rtl/vlcp_queue.sv
rtl/vlcp_back.sv
rtl/variable_length_code_packer_top.sv
test/variable_length_code_packer_top_tb.sv
